@@ hw/rtl/rutf8_pkg.sv @@
// Package for the restricted UTF-8 validator.
// Holds the decoder state type, the byte and code point limits and the reset state.
// No dependencies.
`timescale 1ns / 1ps

package rutf8_pkg;

   localparam int CP_W = 21;

   // Byte classes.
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_DEL     = 8'h7f;
   localparam logic [7:0] ASCII_END     = 8'h80;
   localparam logic [7:0] LEAD2_MIN     = 8'hc2;
   localparam logic [7:0] LEAD2_MAX     = 8'hdf;
   localparam logic [7:0] LEAD3_MIN     = 8'he0;
   localparam logic [7:0] LEAD3_MAX     = 8'hef;
   localparam logic [7:0] LEAD4_MIN     = 8'hf0;
   localparam logic [7:0] LEAD4_MAX     = 8'hf4;
   localparam logic [7:0] CONT_MASK     = 8'hc0;
   localparam logic [7:0] CONT_TAG      = 8'h80;

   // Code point limits.
   localparam logic [CP_W-1:0] CP_C1_MIN   = 21'h00080;
   localparam logic [CP_W-1:0] CP_C1_MAX   = 21'h0009f;
   localparam logic [CP_W-1:0] CP_3B_MIN   = 21'h00800;
   localparam logic [CP_W-1:0] CP_SURR_MIN = 21'h0d800;
   localparam logic [CP_W-1:0] CP_SURR_MAX = 21'h0dfff;
   localparam logic [CP_W-1:0] CP_4B_MIN   = 21'h10000;
   localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;

   // Sequence lengths.
   localparam logic [2:0] SEQ_LEN_1 = 3'd1;
   localparam logic [2:0] SEQ_LEN_2 = 3'd2;
   localparam logic [2:0] SEQ_LEN_3 = 3'd3;
   localparam logic [2:0] SEQ_LEN_4 = 3'd4;

   typedef struct packed {
      logic [1:0]      remaining;
      logic [2:0]      seq_len;
      logic [CP_W-1:0] code_point;
      logic            error_seen;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      remaining:  2'd0,
      seq_len:    SEQ_LEN_1,
      code_point: '0,
      error_seen: 1'b0
   };

endpackage

@@ hw/rtl/rutf8_step.sv @@
// One decode step of the restricted UTF-8 validator: current state and one byte in,
// next state and the verdict for a string ending on this byte out.
// Depends on rutf8_pkg.
`timescale 1ns / 1ps

module rutf8_step
   import rutf8_pkg::*;
(
   input  dec_state_type cur_state,
   input  logic [7:0]    byte_value,
   output dec_state_type nxt_state,
   output logic          text_ok
);

   logic [CP_W-1:0] cp_acc;
   logic [1:0]      rem_dec;
   logic            bad_3b;
   logic            bad_4b;
   logic            bad_c1;

   assign cp_acc  = {cur_state.code_point[CP_W-7:0], byte_value[5:0]};
   assign rem_dec = cur_state.remaining - 2'd1;

   // Range checks on a completed multi-byte sequence.
   assign bad_3b = (cur_state.seq_len == SEQ_LEN_3) &&
                   ((cp_acc < CP_3B_MIN) ||
                    ((cp_acc >= CP_SURR_MIN) && (cp_acc <= CP_SURR_MAX)));
   assign bad_4b = (cur_state.seq_len == SEQ_LEN_4) &&
                   ((cp_acc < CP_4B_MIN) || (cp_acc > CP_MAX));
   assign bad_c1 = (cp_acc >= CP_C1_MIN) && (cp_acc <= CP_C1_MAX);

   always_comb begin
      nxt_state = cur_state;
      if (cur_state.remaining == 2'd0) begin
         priority if (byte_value < ASCII_END) begin
            nxt_state.seq_len    = SEQ_LEN_1;
            nxt_state.code_point = {{(CP_W-8){1'b0}}, byte_value};
            if ((byte_value < ASCII_SPACE) || (byte_value == ASCII_DEL)) begin
               nxt_state.error_seen = 1'b1;
            end
         end else if ((byte_value >= LEAD2_MIN) && (byte_value <= LEAD2_MAX)) begin
            nxt_state.seq_len    = SEQ_LEN_2;
            nxt_state.remaining  = 2'd1;
            nxt_state.code_point = {{(CP_W-5){1'b0}}, byte_value[4:0]};
         end else if ((byte_value >= LEAD3_MIN) && (byte_value <= LEAD3_MAX)) begin
            nxt_state.seq_len    = SEQ_LEN_3;
            nxt_state.remaining  = 2'd2;
            nxt_state.code_point = {{(CP_W-4){1'b0}}, byte_value[3:0]};
         end else if ((byte_value >= LEAD4_MIN) && (byte_value <= LEAD4_MAX)) begin
            nxt_state.seq_len    = SEQ_LEN_4;
            nxt_state.remaining  = 2'd3;
            nxt_state.code_point = {{(CP_W-3){1'b0}}, byte_value[2:0]};
         end else begin
            nxt_state            = DEC_STATE_RESET;
            nxt_state.error_seen = 1'b1;
         end
      end else begin
         // A byte that is not a continuation is consumed as an error, not re-read as a lead.
         if ((byte_value & CONT_MASK) != CONT_TAG) begin
            nxt_state            = DEC_STATE_RESET;
            nxt_state.error_seen = 1'b1;
         end else begin
            nxt_state.code_point = cp_acc;
            nxt_state.remaining  = rem_dec;
            if ((rem_dec == 2'd0) && (bad_3b || bad_4b || bad_c1)) begin
               nxt_state            = DEC_STATE_RESET;
               nxt_state.error_seen = 1'b1;
            end
         end
      end
   end

   assign text_ok = !nxt_state.error_seen && (nxt_state.remaining == 2'd0);

endmodule

@@ hw/rtl/restricted_utf8_validator.sv @@
// Top level of the restricted UTF-8 validator: input register, decode step, result register.
// Depends on rutf8_pkg and rutf8_step.
`timescale 1ns / 1ps

// Checks a text string that arrives one byte per transaction, the final byte flagged by
// req_is_last, and returns one verdict per string on rsp_text_valid (1 = valid UTF-8 with no
// control characters, C1 controls, overlongs, surrogates or code points above U+10FFFF).
// One byte is taken every cycle while the input is not stalled. A string's final byte passes from
// the input register through the decode step, which forms the verdict, into the result
// register. Only a final byte waits for a stalled result; other bytes keep flowing, so the
// input stalls only while a final byte sits behind a result that has not been taken.
module restricted_utf8_validator
   import rutf8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_text_valid
);

   logic          in_vld_ff;
   logic          in_vld_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type step_state;
   logic          step_ok;
   logic          rsp_vld_ff;
   logic          rsp_vld_in;
   logic          rsp_text_ff;
   logic          out_free;
   logic          advance;
   logic          req_take;

   rutf8_step u_step (
      .cur_state  (state_ff),
      .byte_value (in_byte_ff),
      .nxt_state  (step_state),
      .text_ok    (step_ok)
   );

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && (!in_last_ff || out_free);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (!req_stall) begin
         in_vld_in = req_valid;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? DEC_STATE_RESET : step_state;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && in_last_ff) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= DEC_STATE_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_is_last;
      end
      if (advance && in_last_ff) begin
         rsp_text_ff <= step_ok;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_text_valid = rsp_text_ff;

endmodule

@@ hw/rtl/rutf8_checker.sv @@
// Port-level checks for the restricted UTF-8 validator, attached by bind.
// Depends on restricted_utf8_validator.
`timescale 1ns / 1ps

module rutf8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_text_valid
);

   // A stalled result holds its verdict.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_valid))
      else $error("stalled result changed");

   // The input only backs up behind a result that has not been taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending result");

   // A final byte that finds room in the result register once it sits in the input register gives its verdict.
   a_verdict_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_is_last) ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid)
      else $error("verdict missing after final byte");

endmodule

bind restricted_utf8_validator rutf8_checker u_rutf8_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_is_last    (req_is_last),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_valid (rsp_text_valid)
);

@@ tb/testbench.sv @@
// Testbench for restricted_utf8_validator: directed and random strings against an internal
// decoder model, with random idling on both channels and result back-pressure.
// Depends on rutf8_pkg and the RTL of the validator.
`timescale 1ns / 1ps

module testbench;
   import rutf8_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_value;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_text_valid;

   restricted_utf8_validator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_valid (rsp_text_valid)
   );

   dec_state_type decoder = DEC_STATE_RESET;
   logic          expected_verdicts[$];
   logic [7:0]    text_bytes[$];
   logic          expected_verdict;
   int            verdict_errors = 0;
   int            hold_off_cycles = 0;
   bit            req_gaps_on = 1'b0;
   bit            rsp_gaps_on = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("testbench: FAIL");
      $finish;
   end

   // Decoder state after one more byte of the string.
   function automatic dec_state_type utf8_advance(dec_state_type s, logic [7:0] b);
      dec_state_type err;
      err = DEC_STATE_RESET;
      err.error_seen = 1'b1;
      if (s.remaining == 2'd0) begin
         if (b < ASCII_END) begin
            if (b < ASCII_SPACE || b == ASCII_DEL) s = err;
            s.seq_len = SEQ_LEN_1;
            s.code_point = {{(CP_W-8){1'b0}}, b};
         end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            s.seq_len = SEQ_LEN_2;
            s.remaining = 2'd1;
            s.code_point = {{(CP_W-5){1'b0}}, b[4:0]};
         end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            s.seq_len = SEQ_LEN_3;
            s.remaining = 2'd2;
            s.code_point = {{(CP_W-4){1'b0}}, b[3:0]};
         end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            s.seq_len = SEQ_LEN_4;
            s.remaining = 2'd3;
            s.code_point = {{(CP_W-3){1'b0}}, b[2:0]};
         end else begin
            s = err;
         end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
         s = err;
      end else begin
         s.code_point = {s.code_point[CP_W-7:0], b[5:0]};
         s.remaining = s.remaining - 2'd1;
         if (s.remaining == 2'd0) begin
            if (s.seq_len == SEQ_LEN_3 && (s.code_point < CP_3B_MIN ||
                (s.code_point >= CP_SURR_MIN && s.code_point <= CP_SURR_MAX))) begin
               s = err;
            end else if (s.seq_len == SEQ_LEN_4 &&
                         (s.code_point < CP_4B_MIN || s.code_point > CP_MAX)) begin
               s = err;
            end else if (s.code_point >= CP_C1_MIN && s.code_point <= CP_C1_MAX) begin
               s = err;
            end
         end
      end
      return s;
   endfunction

   function automatic int idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      else if (pick < 95) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Appends the UTF-8 form of cp using len bytes, whether or not that length is the
   // shortest one, so overlong and out-of-range forms come from the same encoder.
   function automatic void push_code_point(logic [20:0] cp, int len);
      case (len)
         1: text_bytes.push_back(cp[7:0]);
         2: begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic logic [20:0] legal_code_point(int len);
      case (len)
         1: return 21'($urandom_range(21'h20, 21'h7e));
         2: return 21'($urandom_range(21'ha0, 21'h7ff));
         3: begin
            if ($urandom_range(0, 1) == 0) return 21'($urandom_range(21'h800, 21'hd7ff));
            else return 21'($urandom_range(21'he000, 21'hffff));
         end
         default: return 21'($urandom_range(21'h10000, 21'h10ffff));
      endcase
   endfunction

   function automatic void add_legal_char();
      int len;
      len = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 9))
            0: push_code_point(21'h20, 1);
            1: push_code_point(21'h7e, 1);
            2: push_code_point(21'ha0, 2);
            3: push_code_point(21'h7ff, 2);
            4: push_code_point(21'h800, 3);
            5: push_code_point(21'hd7ff, 3);
            6: push_code_point(21'he000, 3);
            7: push_code_point(21'hffff, 3);
            8: push_code_point(21'h10000, 4);
            default: push_code_point(21'h10ffff, 4);
         endcase
      end else begin
         push_code_point(legal_code_point(len), len);
      end
   endfunction

   function automatic void add_faulty_char();
      int len;
      int k;
      logic [7:0] bad;
      case ($urandom_range(0, 7))
         0: text_bytes.push_back(8'($urandom_range(0, 255)));
         1: begin
            if ($urandom_range(0, 3) == 0) text_bytes.push_back(ASCII_DEL);
            else text_bytes.push_back(8'($urandom_range(0, 31)));
         end
         2: push_code_point(21'($urandom_range(21'h80, 21'h9f)), 2);
         3: begin
            len = $urandom_range(2, 4);
            if (len == 2) push_code_point(21'($urandom_range(0, 21'h7f)), 2);
            else if (len == 3) push_code_point(21'($urandom_range(0, 21'h7ff)), 3);
            else push_code_point(21'($urandom_range(0, 21'hffff)), 4);
         end
         4: push_code_point(21'($urandom_range(21'hd800, 21'hdfff)), 3);
         5: push_code_point(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
         6: begin
            // A legal multi-byte sequence with one continuation byte replaced.
            len = $urandom_range(2, 4);
            push_code_point(legal_code_point(len), len);
            k = text_bytes.size() - int'($urandom_range(1, len - 1));
            bad = 8'($urandom_range(0, 255));
            if (bad[7:6] == 2'b10) bad[6] = 1'b1;
            text_bytes[k] = bad;
         end
         default: text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      endcase
   endfunction

   // Offers one byte and waits for its transaction, then advances the decoder model.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_is_last    <= last;
      do @(posedge clock); while (req_stall);
      decoder = utf8_advance(decoder, b);
      if (last) begin
         expected_verdicts.push_back(!decoder.error_seen && decoder.remaining == 2'd0);
         decoder = DEC_STATE_RESET;
      end
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic random_string();
      text_bytes.delete();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 99) < 80) add_legal_char();
         else add_faulty_char();
      end
      // Sometimes the last byte is dropped, which can end the string in the middle of its last sequence.
      if ($urandom_range(0, 19) == 0 && text_bytes.size() > 1) void'(text_bytes.pop_back());
      send_text();
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   task automatic test_directed();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      text_bytes = '{8'h41}; send_text();
      text_bytes = '{8'h00}; send_text();
      text_bytes = '{8'h7f}; send_text();
      text_bytes = '{8'hff}; send_text();
      text_bytes = '{8'hc0}; send_text();
      text_bytes = '{8'hc2, 8'h80}; send_text();
      text_bytes = '{8'hdf, 8'hbf}; send_text();
      text_bytes = '{8'he0, 8'h9f, 8'hbf}; send_text();
      text_bytes = '{8'hed, 8'ha0, 8'h80}; send_text();
      text_bytes = '{8'hf0, 8'h8f, 8'hbf, 8'hbf}; send_text();
      text_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_text();
      text_bytes = '{8'he2, 8'h82}; send_text();
      text_bytes = '{8'hc3, 8'h41, 8'h20}; send_text();
      text_bytes = '{8'h7e}; send_text();
   endtask

   task automatic test_random_strings();
      int sent;
      sent = 0;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      while (sent < 800) begin
         if ($urandom_range(0, 14) == 0) begin
            req_gaps_on = $urandom_range(0, 3) != 0;
            rsp_gaps_on = $urandom_range(0, 3) != 0;
         end
         random_string();
         sent += text_bytes.size();
      end
   endtask

   // The result side holds off long enough for the pipeline to fill and stall the input.
   task automatic test_result_backpressure();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_off_cycles = 150;
      repeat (40) begin
         text_bytes.delete();
         if ($urandom_range(0, 1) == 0) add_legal_char();
         else add_faulty_char();
         send_text();
      end
   endtask

   task automatic test_sender_pause();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (8) random_string();
      wait_for_verdicts();
      repeat (8) random_string();
   endtask

   initial begin : result_stall_gen
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length() + 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict transaction: expected none, actual %b",
                     $time, rsp_text_valid);
            verdict_errors++;
         end else begin
            expected_verdict = expected_verdicts.pop_front();
            if (rsp_text_valid !== expected_verdict) begin
               $display("%0t: text_valid mismatch: expected %b, actual %b",
                        $time, expected_verdict, rsp_text_valid);
               verdict_errors++;
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_byte_value <= 8'h00;
      req_is_last    <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_result_backpressure();
      test_sender_pause();
      test_random_strings();

      req_valid <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (expected_verdicts.size() != 0 && wait_cycles < 2000);
      if (expected_verdicts.size() != 0) begin
         $display("%0t: %0d verdicts missing: expected %b first, actual none",
                  $time, expected_verdicts.size(), expected_verdicts[0]);
         verdict_errors++;
      end
      repeat (8) @(posedge clock);
      if (verdict_errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
